### hw/rtl/kdt_pkg.sv
// Shared types and constants for the keyed deque table.
package kdt_pkg;

  localparam int KEY_W        = 32;
  localparam int VAL_W        = 32;
  localparam int COUNT_W      = 7;
  localparam int DEF_CAPACITY = 64;

  typedef enum logic [2:0] {
    FN_PUSH_BACK  = 3'd0,
    FN_PUSH_FRONT = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_SEARCH     = 3'd4,
    FN_UPDATE     = 3'd5,
    FN_MAX        = 3'd6
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_NOKEY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SH_HOLD,
    SH_LEFT,
    SH_RIGHT
  } shift_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [VAL_W-1:0]        value;
  } entry_t;

  typedef struct packed {
    status_t status;
    entry_t  ent;
  } result_t;

  typedef struct packed {
    logic start;
    logic step;
    logic in_range;
    logic at_last;
    logic at_end;
  } scan_ctl_t;

endpackage

### hw/rtl/kdt_if.sv
// Request and response channel interfaces of the keyed deque table.
interface kdt_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         func;
  logic signed [31:0] item_key;
  logic [31:0]        item_value;

  modport source (output valid, func, item_key, item_value, input ready);
  modport sink (input valid, func, item_key, item_value, output ready);
endinterface

interface kdt_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] found_key;
  logic [31:0]        found_value;
  logic [6:0]         entry_count;

  modport source (output valid, status, found_key, found_value, entry_count, input ready);
  modport sink (input valid, status, found_key, found_value, entry_count, output ready);
endinterface

### hw/rtl/keyed_deque_table.sv
// Top level of the keyed deque table: cell chain, walk unit and control.
//
//  channel | role   | payload
//  --------+--------+---------------------------------------------------
//  req     | sink   | func, item_key, item_value
//  rsp     | source | status, found_key, found_value, entry_count
//
// Push front and pop front shift the cell chain once, then pass through the finish state to the result.
// Push back, pop back, search, update and max rotate the ring a full turn in the walk
// state before they finish; the front always rests in cell 0.
// Full, empty and unused-code cases go straight to the finish state without touching the cells.
// Reset clears the count and control; cell contents are not cleared.
// A new request is taken once the previous result sits in the output register;
// a stalled response holds the block in its finish state.
module keyed_deque_table
  import kdt_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic      clk,
  input  logic      rst,
  kdt_req_if.sink   req,
  kdt_rsp_if.source rsp
);

  localparam int OCC_W  = $clog2(CAPACITY + 1);
  localparam int STEP_W = $clog2(CAPACITY);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CAPACITY - 1);
  localparam logic [OCC_W-1:0]  CAP_OCC   = OCC_W'(CAPACITY);

  state_t              state, state_next;
  logic [OCC_W-1:0]    occ, occ_next;
  logic [STEP_W-1:0]   step, step_next;
  func_t               op, op_next;
  entry_t              item, item_next;
  result_t             pend, pend_next;
  logic                walked, walked_next;
  result_t             res;
  logic [COUNT_W-1:0]  res_cnt;
  logic                res_valid;
  logic                res_load;
  logic                accept;
  logic                full, empty;
  shift_t              shift;
  entry_t              ins, wrap;
  entry_t              scan_wrap;
  result_t             scan_res;
  scan_ctl_t           ctl;
  logic [OCC_W-1:0]    step_ext;

  entry_t cell_q [CAPACITY];

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign full      = (occ == CAP_OCC);
  assign empty     = (occ == '0);
  assign step_ext  = OCC_W'(step);

  // Cell chain: left shift rotates toward cell 0, right shift inserts at cell 0.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t prev_e, next_e;
    assign prev_e = (i == 0) ? ins : cell_q[(i == 0) ? 0 : i - 1];
    assign next_e = (i == CAPACITY - 1) ? wrap : cell_q[(i == CAPACITY - 1) ? 0 : i + 1];
    kdt_cell u_cell (
      .clk  (clk),
      .op   (shift),
      .prev (prev_e),
      .next (next_e),
      .q    (cell_q[i])
    );
  end

  assign ctl.start    = accept;
  assign ctl.step     = (state == S_WALK);
  assign ctl.in_range = (step_ext < occ);
  assign ctl.at_last  = ((step_ext + OCC_W'(1)) == occ);
  assign ctl.at_end   = (step_ext == occ);

  kdt_scan u_scan (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .op   (op),
    .item (item),
    .head (cell_q[0]),
    .wrap (scan_wrap),
    .res  (scan_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occ       <= '0;
      step      <= '0;
      res_valid <= 1'b0;
      walked    <= 1'b0;
    end else begin
      state  <= state_next;
      occ    <= occ_next;
      step   <= step_next;
      walked <= walked_next;
      if (res_load) res_valid <= 1'b1;
      else if (rsp.ready) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    op   <= op_next;
    item <= item_next;
    pend <= pend_next;
    if (res_load) begin
      res     <= walked ? scan_res : pend;
      res_cnt <= COUNT_W'(occ);
    end
  end

  always_comb begin
    state_next  = state;
    occ_next    = occ;
    step_next   = step;
    op_next     = op;
    item_next   = item;
    pend_next   = pend;
    walked_next = walked;
    res_load    = 1'b0;
    shift       = SH_HOLD;
    ins.key     = req.item_key;
    ins.value   = req.item_value;
    wrap        = cell_q[0];

    case (state)
      S_IDLE: begin
        if (accept) begin
          op_next        = func_t'(req.func);
          item_next.key  = req.item_key;
          item_next.value = req.item_value;
          pend_next      = '{status: ST_OK, ent: '0};
          walked_next    = 1'b0;
          state_next     = S_FINISH;
          case (func_t'(req.func))
            FN_PUSH_BACK: begin
              if (full) pend_next.status = ST_FULL;
              else begin
                walked_next = 1'b1;
                state_next  = S_WALK;
              end
            end
            FN_PUSH_FRONT: begin
              if (full) pend_next.status = ST_FULL;
              else begin
                shift         = SH_RIGHT;
                occ_next      = occ + OCC_W'(1);
                pend_next.ent = ins;
              end
            end
            FN_POP_FRONT: begin
              if (empty) pend_next.status = ST_EMPTY;
              else begin
                shift         = SH_LEFT;
                occ_next      = occ - OCC_W'(1);
                pend_next.ent = cell_q[0];
              end
            end
            FN_POP_BACK, FN_MAX: begin
              if (empty) pend_next.status = ST_EMPTY;
              else begin
                walked_next = 1'b1;
                state_next  = S_WALK;
              end
            end
            FN_SEARCH, FN_UPDATE: begin
              walked_next = 1'b1;
              state_next  = S_WALK;
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        shift     = SH_LEFT;
        wrap      = scan_wrap;
        step_next = step + STEP_W'(1);
        if (step == LAST_STEP) begin
          step_next  = '0;
          state_next = S_FINISH;
          if (op == FN_PUSH_BACK) occ_next = occ + OCC_W'(1);
          else if (op == FN_POP_BACK) occ_next = occ - OCC_W'(1);
        end
      end
      S_FINISH: begin
        if (!res_valid || rsp.ready) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign rsp.valid       = res_valid;
  assign rsp.status      = res.status;
  assign rsp.found_key   = res.ent.key;
  assign rsp.found_value = res.ent.value;
  assign rsp.entry_count = res_cnt;

  a_occ_bound : assert property (@(posedge clk) disable iff (rst) occ <= CAP_OCC)
    else $error("entry count beyond capacity");

  a_step_idle : assert property (@(posedge clk) disable iff (rst)
    state != S_WALK |-> step == '0)
    else $error("walk counter moved outside a walk");

  a_busy_after_accept : assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("request taken without work started");

  a_push_front_count : assert property (@(posedge clk) disable iff (rst)
    (accept && req.func == FN_PUSH_FRONT && !full) |=> occ == $past(occ) + OCC_W'(1))
    else $error("push front did not grow the deque");

endmodule

### hw/rtl/kdt_cell.sv
// One storage cell of the deque chain: holds one entry, shifts with its neighbors.
module kdt_cell
  import kdt_pkg::*;
(
  input  logic   clk,
  input  shift_t op,
  input  entry_t prev,
  input  entry_t next,
  output entry_t q
);

  always_ff @(posedge clk) begin
    case (op)
      SH_LEFT:  q <= next;
      SH_RIGHT: q <= prev;
      default:  q <= q;
    endcase
  end

endmodule

### hw/rtl/kdt_scan.sv
// Walk unit: watches the front cell while the ring rotates and gathers the result.
module kdt_scan
  import kdt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  scan_ctl_t ctl,
  input  func_t     op,
  input  entry_t    item,
  input  entry_t    head,
  output entry_t    wrap,
  output result_t   res
);

  logic   hit;
  entry_t found;
  logic   first;

  assign first = !hit && ctl.in_range && (head.key == item.key);

  // Entry leaving the front re-enters at the back, changed where the op asks.
  always_comb begin
    wrap = head;
    if (op == FN_UPDATE && first) wrap.value = item.value;
    if (op == FN_PUSH_BACK && ctl.at_end) wrap = item;
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.start) begin
      hit <= 1'b0;
    end else if (ctl.step) begin
      case (op)
        FN_SEARCH, FN_UPDATE: begin
          if (first) begin
            hit   <= 1'b1;
            found <= wrap;
          end
        end
        FN_MAX: begin
          // strict compare keeps ties at the entry nearest the front
          if (ctl.in_range && (!hit || head.value > found.value)) begin
            hit   <= 1'b1;
            found <= head;
          end
        end
        FN_POP_BACK: begin
          if (ctl.at_last) begin
            hit   <= 1'b1;
            found <= head;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res.status = ST_OK;
    res.ent    = '0;
    case (op)
      FN_PUSH_BACK:          res.ent = item;
      FN_POP_BACK, FN_MAX:   res.ent = found;
      FN_SEARCH, FN_UPDATE: begin
        if (hit) res.ent = found;
        else res.status = ST_NOKEY;
      end
      default: ;
    endcase
  end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the keyed deque table: directed table, random ops, deque predictor.
module tb;
  import kdt_pkg::*;

  localparam logic [2:0] FN_UNUSED        = 3'd7;
  localparam int         RANDOM_PER_PHASE = 250;
  localparam int         HOLD_CYCLES      = 400;
  // Longest quiet stretch: a full ring turn plus the long receiver hold, many times over.
  localparam int         QUIET_LIMIT      = 20000;

  typedef enum logic [1:0] {
    PACE_RX_LAGS,
    PACE_TX_LAGS,
    PACE_FLAT
  } pace_t;

  typedef struct packed {
    logic [2:0]              fn;
    logic signed [KEY_W-1:0] key;
    logic [VAL_W-1:0]        value;
  } request_t;

  typedef struct packed {
    status_t              status;
    entry_t               ent;
    logic [COUNT_W-1:0]   count;
  } outcome_t;

  typedef struct packed {
    request_t rq;
    logic     typed;
    outcome_t want;
  } directed_row_t;

  logic clk;
  logic rst;

  kdt_req_if req ();
  kdt_rsp_if rsp ();

  keyed_deque_table dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  entry_t        ledger[$];            // front of the deque at index 0
  outcome_t      pending_outcomes[$];
  directed_row_t dir_tab[$];
  pace_t         pace;
  logic          hold_flag;
  logic          hold_seen;
  int            hold_left;
  int            quiet_cycles = 0;
  int            err_count = 0;
  int            sent_count;
  int            checked_count = 0;
  int            full_seen = 0;
  int            empty_seen = 0;
  int            nokey_seen = 0;

  logic signed [KEY_W-1:0] key_pool[6] = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff,
                                          32'h0, 32'h1, 32'h2a};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic outcome_t apply_to_ledger(input request_t rq);
    outcome_t o;
    int       hit;
    o        = '0;
    o.status = ST_OK;
    hit      = -1;
    case (rq.fn)
      FN_PUSH_BACK, FN_PUSH_FRONT: begin
        if (ledger.size() >= DEF_CAPACITY) begin
          o.status = ST_FULL;
        end else begin
          o.ent.key   = rq.key;
          o.ent.value = rq.value;
          if (rq.fn == FN_PUSH_BACK) ledger.push_back(o.ent);
          else ledger.push_front(o.ent);
        end
      end
      FN_POP_FRONT, FN_POP_BACK: begin
        if (ledger.size() == 0) o.status = ST_EMPTY;
        else if (rq.fn == FN_POP_FRONT) o.ent = ledger.pop_front();
        else o.ent = ledger.pop_back();
      end
      FN_SEARCH, FN_UPDATE: begin
        for (int i = 0; i < ledger.size(); i++) begin
          if (ledger[i].key == rq.key) begin
            hit = i;
            break;
          end
        end
        if (hit < 0) begin
          o.status = ST_NOKEY;
        end else begin
          if (rq.fn == FN_UPDATE) ledger[hit].value = rq.value;
          o.ent = ledger[hit];
        end
      end
      FN_MAX: begin
        if (ledger.size() == 0) begin
          o.status = ST_EMPTY;
        end else begin
          // strict compare keeps the entry nearest the front on ties
          hit = 0;
          for (int i = 1; i < ledger.size(); i++)
            if (ledger[i].value > ledger[hit].value) hit = i;
          o.ent = ledger[hit];
        end
      end
      default: ;
    endcase
    o.count = COUNT_W'(ledger.size());
    return o;
  endfunction

  function automatic directed_row_t dir_row(input logic [2:0] fn, input logic [31:0] key,
                                            input logic [31:0] value, input logic typed,
                                            input status_t st, input logic [31:0] ekey,
                                            input logic [31:0] evalue, input int cnt);
    directed_row_t r;
    r.rq.fn            = fn;
    r.rq.key           = key;
    r.rq.value         = value;
    r.typed            = typed;
    r.want.status      = st;
    r.want.ent.key     = ekey;
    r.want.ent.value   = evalue;
    r.want.count       = COUNT_W'(cnt);
    return r;
  endfunction

  function automatic request_t shape_request(input logic [2:0] fn);
    request_t rq;
    int       pick;
    rq.fn = fn;
    pick  = $urandom_range(0, 9);
    if (pick < 4 && ledger.size() != 0) rq.key = ledger[$urandom_range(0, ledger.size() - 1)].key;
    else if (pick < 7) rq.key = key_pool[$urandom_range(0, 5)];
    else rq.key = $urandom;
    pick = $urandom_range(0, 9);
    if (pick < 2) rq.value = '0;
    else if (pick < 4) rq.value = '1;
    else if (pick < 6) rq.value = $urandom_range(0, 7);   // small values force ties
    else rq.value = $urandom;
    return rq;
  endfunction

  task automatic offer(input request_t rq, input logic typed = 1'b0, input outcome_t want = '0);
    outcome_t predicted;
    int       pct;
    pct = (pace == PACE_RX_LAGS) ? 10 : (pace == PACE_TX_LAGS) ? 69 : 0;
    if ($urandom_range(0, 99) < pct) begin
      req.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < pct);
    end
    req.valid      <= 1'b1;
    req.func       <= rq.fn;
    req.item_key   <= rq.key;
    req.item_value <= rq.value;
    do @(posedge clk); while (!req.ready);
    predicted = apply_to_ledger(rq);
    pending_outcomes.push_back(typed ? want : predicted);
    sent_count++;
  endtask

  // response side: check each transfer, then pick next ready
  always @(posedge clk) begin : rsp_side
    outcome_t want;
    if (rst) begin
      rsp.ready <= 1'b0;
      hold_left <= 0;
      hold_seen <= hold_flag;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (pending_outcomes.size() == 0) begin
          $error("response with nothing outstanding: status %0d key %0h value %0h count %0d",
                 rsp.status, rsp.found_key, rsp.found_value, rsp.entry_count);
          err_count++;
        end else begin
          want = pending_outcomes.pop_front();
          checked_count++;
          if (want.status == ST_FULL) full_seen++;
          if (want.status == ST_EMPTY) empty_seen++;
          if (want.status == ST_NOKEY) nokey_seen++;
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            err_count++;
          end
          if (rsp.found_key !== want.ent.key) begin
            $error("found_key: expected %0h, got %0h", want.ent.key, rsp.found_key);
            err_count++;
          end
          if (rsp.found_value !== want.ent.value) begin
            $error("found_value: expected %0h, got %0h", want.ent.value, rsp.found_value);
            err_count++;
          end
          if (rsp.entry_count !== want.count) begin
            $error("entry_count: expected %0d, got %0d", want.count, rsp.entry_count);
            err_count++;
          end
        end
      end
      if (hold_flag != hold_seen) begin
        hold_seen <= hold_flag;
        hold_left <= HOLD_CYCLES;
        rsp.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= $urandom_range(0, 99) >=
                     ((pace == PACE_RX_LAGS) ? 69 : (pace == PACE_TX_LAGS) ? 10 : 0);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("keyed_deque_table regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int sel;
    sent_count     = 0;
    rst            <= 1'b1;
    req.valid      <= 1'b0;
    req.func       <= FN_PUSH_BACK;
    req.item_key   <= '0;
    req.item_value <= '0;
    hold_flag      <= 1'b0;
    pace           <= PACE_RX_LAGS;

    // empty-deque errors, unused code, extremes, ties, duplicate keys
    dir_tab.push_back(dir_row(FN_POP_FRONT, 32'h0, 32'h0, 1'b1, ST_EMPTY, 0, 0, 0));
    dir_tab.push_back(dir_row(FN_POP_BACK, 32'hffff_ffff, 32'hffff_ffff, 1'b1, ST_EMPTY,
                              0, 0, 0));
    dir_tab.push_back(dir_row(FN_MAX, 32'h0, 32'h0, 1'b1, ST_EMPTY, 0, 0, 0));
    dir_tab.push_back(dir_row(FN_SEARCH, 32'h7fff_ffff, 32'h0, 1'b1, ST_NOKEY, 0, 0, 0));
    dir_tab.push_back(dir_row(FN_UPDATE, 32'h8000_0000, 32'hffff_ffff, 1'b1, ST_NOKEY,
                              0, 0, 0));
    dir_tab.push_back(dir_row(FN_UNUSED, 32'h1234_5678, 32'h9abc_def0, 1'b1, ST_OK, 0, 0, 0));
    dir_tab.push_back(dir_row(FN_PUSH_BACK, 32'h7fff_ffff, 32'hffff_ffff, 1'b1, ST_OK,
                              32'h7fff_ffff, 32'hffff_ffff, 1));
    dir_tab.push_back(dir_row(FN_PUSH_FRONT, 32'h8000_0000, 32'h0, 1'b1, ST_OK,
                              32'h8000_0000, 32'h0, 2));
    dir_tab.push_back(dir_row(FN_PUSH_BACK, 32'hffff_ffff, 32'hffff_ffff, 1'b1, ST_OK,
                              32'hffff_ffff, 32'hffff_ffff, 3));
    dir_tab.push_back(dir_row(FN_MAX, 32'h0, 32'h0, 1'b0, ST_OK, 0, 0, 0));
    dir_tab.push_back(dir_row(FN_SEARCH, 32'hffff_ffff, 32'h0, 1'b0, ST_OK, 0, 0, 0));
    dir_tab.push_back(dir_row(FN_UPDATE, 32'h7fff_ffff, 32'h0, 1'b0, ST_OK, 0, 0, 0));
    dir_tab.push_back(dir_row(FN_MAX, 32'h0, 32'h0, 1'b0, ST_OK, 0, 0, 0));
    dir_tab.push_back(dir_row(FN_SEARCH, 32'h0, 32'h0, 1'b1, ST_NOKEY, 0, 0, 3));
    dir_tab.push_back(dir_row(FN_PUSH_FRONT, 32'hffff_ffff, 32'h5, 1'b0, ST_OK, 0, 0, 0));
    dir_tab.push_back(dir_row(FN_SEARCH, 32'hffff_ffff, 32'h0, 1'b0, ST_OK, 0, 0, 0));
    dir_tab.push_back(dir_row(FN_UPDATE, 32'hffff_ffff, 32'h1, 1'b0, ST_OK, 0, 0, 0));
    dir_tab.push_back(dir_row(FN_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 1'b1, ST_OK, 0, 0, 4));
    dir_tab.push_back(dir_row(FN_POP_BACK, 32'h0, 32'h0, 1'b0, ST_OK, 0, 0, 0));
    dir_tab.push_back(dir_row(FN_POP_FRONT, 32'h0, 32'h0, 1'b0, ST_OK, 0, 0, 0));
    dir_tab.push_back(dir_row(FN_MAX, 32'h0, 32'h0, 1'b0, ST_OK, 0, 0, 0));
    dir_tab.push_back(dir_row(FN_POP_FRONT, 32'h0, 32'h0, 1'b0, ST_OK, 0, 0, 0));
    dir_tab.push_back(dir_row(FN_POP_FRONT, 32'h0, 32'h0, 1'b0, ST_OK, 0, 0, 0));
    dir_tab.push_back(dir_row(FN_POP_BACK, 32'h0, 32'h0, 1'b1, ST_EMPTY, 0, 0, 0));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) offer(dir_tab[i].rq, dir_tab[i].typed, dir_tab[i].want);

    for (int m = 0; m < 3; m++) begin
      pace <= pace_t'(m);
      if (pace_t'(m) == PACE_TX_LAGS) begin
        // fill to capacity, overflow from both ends, then drain past empty
        while (ledger.size() < DEF_CAPACITY)
          offer(shape_request($urandom_range(0, 1) ? FN_PUSH_BACK : FN_PUSH_FRONT));
        offer(shape_request(FN_PUSH_BACK));
        offer(shape_request(FN_PUSH_FRONT));
        offer(shape_request(FN_SEARCH));
        offer(shape_request(FN_UPDATE));
        offer(shape_request(FN_MAX));
        while (ledger.size() != 0)
          offer(shape_request($urandom_range(0, 1) ? FN_POP_BACK : FN_POP_FRONT));
        offer(shape_request(FN_POP_BACK));
        offer(shape_request(FN_MAX));
      end
      // stall the response side long enough for the request side to back up
      if (pace_t'(m) == PACE_FLAT) hold_flag <= ~hold_flag;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 20) offer(shape_request(FN_PUSH_BACK));
        else if (sel < 35) offer(shape_request(FN_PUSH_FRONT));
        else if (sel < 47) offer(shape_request(FN_POP_FRONT));
        else if (sel < 57) offer(shape_request(FN_POP_BACK));
        else if (sel < 72) offer(shape_request(FN_SEARCH));
        else if (sel < 84) offer(shape_request(FN_UPDATE));
        else if (sel < 95) offer(shape_request(FN_MAX));
        else offer(shape_request(FN_UNUSED));
      end
    end
    req.valid <= 1'b0;

    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DEF_CAPACITY + 8) @(posedge clk);

    $display("%0d requests over three pacing phases, %0d responses checked", sent_count,
             checked_count);
    $display("status mix: %0d full, %0d empty, %0d missing key", full_seen, empty_seen,
             nokey_seen);
    if (err_count == 0) begin
      $display("keyed_deque_table regression: pass");
    end else begin
      $display("keyed_deque_table regression: fail");
    end
    $finish;
  end

endmodule
